// ===== hdl/dc_pkg.sv =====
// Shared types and constants for the door controller with button lock.
// No dependencies; every other file in hdl/ imports this package.
package dc_pkg;

    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int TIMER_BITS_DEF = 16;
    localparam int Q_DEPTH        = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(10000);
    localparam logic [CFG_W-1:0] TIMEOUT_RST    = CFG_W'(10000);
    localparam logic [CFG_W-1:0] LAMP_RST       = CFG_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_LAMP       = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DOOR_START   = 3'd0,
        DOOR_BOTTOM  = 3'd1,
        DOOR_TOP     = 3'd2,
        DOOR_MIDWAY  = 3'd3,
        DOOR_RISING  = 3'd4,
        DOOR_FALLING = 3'd5,
        DOOR_LOCKED  = 3'd6
    } t_door;

    // One classified tick handed from the button front end to the door machine.
    typedef struct packed {
        logic short_evt;
        logic long_evt;
        logic lamp_on;
        logic top_hit;
        logic bottom_hit;
    } t_event;

    // Button timing settings used by the front end.
    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] lamp_pulse_ms;
    } t_front_cfg;

endpackage

// ===== hdl/dc_ifs.sv =====
// Handshake channel interfaces of the door controller: tick input, result
// output and configuration write. Depends on dc_pkg.
interface dc_tick_if;
    logic valid;
    logic ready;
    logic button_level;
    logic top_switch_level;
    logic bottom_switch_level;
    modport source(output valid, output button_level, output top_switch_level,
                   output bottom_switch_level, input ready);
    modport sink(input valid, input button_level, input top_switch_level,
                 input bottom_switch_level, output ready);
endinterface

interface dc_result_if;
    logic       valid;
    logic       ready;
    logic       drive_up;
    logic       drive_down;
    logic       press_lamp;
    logic [2:0] door_state;
    modport source(output valid, output drive_up, output drive_down,
                   output press_lamp, output door_state, input ready);
    modport sink(input valid, input drive_up, input drive_down,
                 input press_lamp, input door_state, output ready);
endinterface

interface dc_cfg_if;
    import dc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/dc_front.sv =====
// Button front end: debounce, press classification, long-press detection and
// the press lamp pulse. Depends on dc_pkg and dc_ifs.
module dc_front
    import dc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dc_tick_if.sink    i_tick,
    input  t_front_cfg i_cfg,
    input  logic       i_q_full,
    output logic       o_push,
    output t_event     o_event
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == TMAX) ? v : v + 1'b1;
    endfunction

    logic                  r_prev_raw, r_settled, r_held, r_long_seen, r_ral, r_lamp_on;
    logic [TIMER_BITS-1:0] r_since, r_hold, r_lamp_el;

    logic                  n_prev_raw, n_settled, n_held, n_long_seen, n_ral, n_lamp_on;
    logic [TIMER_BITS-1:0] n_since, n_hold, n_lamp_el;
    logic                  settle, press, release_evt, short_evt, long_evt;

    assign i_tick.ready = !i_q_full;
    assign o_push       = i_tick.valid && !i_q_full;

    always_comb begin
        n_prev_raw  = i_tick.button_level;
        n_since     = (i_tick.button_level != r_prev_raw) ? '0 : sat_inc(r_since);
        settle      = (CMP_W'(n_since) > CMP_W'(i_cfg.settle_ms))
                      && (i_tick.button_level != r_settled);
        press       = settle && !i_tick.button_level;
        release_evt = settle && i_tick.button_level && r_held;
        n_settled   = settle ? i_tick.button_level : r_settled;

        n_held      = press ? 1'b1 : (release_evt ? 1'b0 : r_held);
        n_long_seen = press ? 1'b0 : r_long_seen;
        n_hold      = press ? '0 : sat_inc(r_hold);
        n_lamp_on   = press ? 1'b1 : r_lamp_on;
        n_lamp_el   = press ? '0 : sat_inc(r_lamp_el);
        short_evt   = release_evt && !r_long_seen;
        n_ral       = release_evt ? 1'b1 : r_ral;

        long_evt = n_held && n_ral && (CMP_W'(n_hold) >= CMP_W'(i_cfg.long_press_ms));
        if (long_evt) begin
            n_long_seen = 1'b1;
            n_ral       = 1'b0;
        end

        if (n_lamp_on && (CMP_W'(n_lamp_el) >= CMP_W'(i_cfg.lamp_pulse_ms))) begin
            n_lamp_on = 1'b0;
        end

        o_event.short_evt  = short_evt;
        o_event.long_evt   = long_evt;
        o_event.lamp_on    = n_lamp_on;
        o_event.top_hit    = !i_tick.top_switch_level;
        o_event.bottom_hit = !i_tick.bottom_switch_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= 1'b1;
            r_settled   <= 1'b1;
            r_since     <= '0;
            r_held      <= 1'b0;
            r_long_seen <= 1'b0;
            r_ral       <= 1'b1;
            r_hold      <= '0;
            r_lamp_on   <= 1'b0;
            r_lamp_el   <= '0;
        end else if (o_push) begin
            r_prev_raw  <= n_prev_raw;
            r_settled   <= n_settled;
            r_since     <= n_since;
            r_held      <= n_held;
            r_long_seen <= n_long_seen;
            r_ral       <= n_ral;
            r_hold      <= n_hold;
            r_lamp_on   <= n_lamp_on;
            r_lamp_el   <= n_lamp_el;
        end
    end

endmodule

// ===== hdl/dc_queue.sv =====
// Two-entry queue of classified ticks between the button front end and the
// door machine. Depends on dc_pkg.
module dc_queue
    import dc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_event o_event
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_event           r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/dc_back.sv =====
// Door state machine: drives the registered result channel and takes one
// classified tick per cycle while it is free or taken. Uses dc_pkg, dc_ifs.
module dc_back
    import dc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_event           i_event,
    input  logic [CFG_W-1:0] i_timeout_ms,
    output logic             o_pop,
    dc_result_if.source      o_result
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    t_door                 r_mode, n_mode, target;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic                  r_last_up, n_last_up, r_short, n_short, r_long, n_long;
    logic                  r_out_valid, r_drive_up, r_drive_down, r_lamp;
    logic [2:0]            r_state_out;
    logic                  do_enter, timed_out;

    assign o_pop               = i_q_valid && (!r_out_valid || o_result.ready);
    assign o_result.valid      = r_out_valid;
    assign o_result.drive_up   = r_drive_up;
    assign o_result.drive_down = r_drive_down;
    assign o_result.press_lamp = r_lamp;
    assign o_result.door_state = r_state_out;

    always_comb begin
        n_elapsed = (r_elapsed == TMAX) ? r_elapsed : r_elapsed + 1'b1;
        n_short   = r_short | i_event.short_evt;
        n_long    = r_long | i_event.long_evt;
        n_mode    = r_mode;
        n_last_up = r_last_up;
        timed_out = CMP_W'(n_elapsed) >= CMP_W'(i_timeout_ms);
        do_enter  = 1'b0;
        target    = DOOR_BOTTOM;

        unique case (r_mode)
            DOOR_BOTTOM: begin
                if (n_long) begin
                    do_enter = 1'b1;
                    target   = DOOR_LOCKED;
                end else if (n_short) begin
                    do_enter = 1'b1;
                    target   = DOOR_RISING;
                end
            end
            DOOR_LOCKED: begin
                if (n_long) begin
                    do_enter = 1'b1;
                    target   = DOOR_BOTTOM;
                end
            end
            DOOR_TOP: begin
                if (n_short) begin
                    do_enter = 1'b1;
                    target   = DOOR_FALLING;
                end
            end
            DOOR_MIDWAY: begin
                // A press in midway reverses the last direction of travel.
                if (n_short) begin
                    do_enter = 1'b1;
                    target   = r_last_up ? DOOR_FALLING : DOOR_RISING;
                end
            end
            DOOR_RISING: begin
                if (n_short) begin
                    do_enter = 1'b1;
                    target   = DOOR_MIDWAY;
                end else if (i_event.top_hit || timed_out) begin
                    do_enter = 1'b1;
                    target   = DOOR_TOP;
                end
            end
            DOOR_FALLING: begin
                if (n_short) begin
                    do_enter = 1'b1;
                    target   = DOOR_MIDWAY;
                end else if (i_event.bottom_hit || timed_out) begin
                    do_enter = 1'b1;
                    target   = DOOR_BOTTOM;
                end
            end
            default: begin
                do_enter = 1'b1;
                target   = DOOR_BOTTOM;
            end
        endcase

        if (do_enter) begin
            n_mode    = target;
            n_elapsed = '0;
            n_short   = 1'b0;
            n_long    = 1'b0;
            if (target == DOOR_BOTTOM || target == DOOR_FALLING) begin
                n_last_up = 1'b0;
            end else if (target == DOOR_TOP || target == DOOR_RISING) begin
                n_last_up = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= DOOR_START;
            r_elapsed   <= '0;
            r_last_up   <= 1'b0;
            r_short     <= 1'b0;
            r_long      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode       <= n_mode;
                r_elapsed    <= n_elapsed;
                r_last_up    <= n_last_up;
                r_short      <= n_short;
                r_long       <= n_long;
                r_out_valid  <= 1'b1;
                r_drive_up   <= (n_mode == DOOR_RISING);
                r_drive_down <= (n_mode == DOOR_FALLING);
                r_lamp       <= i_event.lamp_on;
                r_state_out  <= n_mode;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/door_controller_with_button_lock.sv =====
// Door controller with button lock.
// Usage: each request on i_tick is one millisecond tick carrying the raw,
// active-low button and limit switch levels. Every tick yields exactly one
// request on o_result with the motor drives, the press lamp and the door state.
// i_cfg writes the four timing registers (debounce, long press, move timeout,
// lamp pulse) by index; it is always ready and should only be used while idle.
// An accepted tick passes through the queue and the output register. Throughput
// is one tick per cycle, set by the door machine, which takes one queued tick
// each cycle that its output register is free or taken.
// The button front end and the door machine are joined by a two-entry queue,
// so a stalled receiver first fills the output register, then the queue, and
// only then drops i_tick.ready; nothing is lost or repeated.
// Reset (synchronous, active low) restores the register defaults, empties the
// queue and the output register, and puts the door machine in the start state,
// which moves to bottom on the first tick.
module door_controller_with_button_lock
    import dc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dc_tick_if.sink     i_tick,
    dc_cfg_if.sink      i_cfg,
    dc_result_if.source o_result
);

    logic [CFG_W-1:0] r_debounce, r_long_press, r_timeout, r_lamp_pulse;
    t_front_cfg       front_cfg;
    t_event           push_event, pop_event;
    logic             push, pop, q_full, q_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
            r_timeout    <= TIMEOUT_RST;
            r_lamp_pulse <= LAMP_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DEBOUNCE:   r_debounce   <= i_cfg.data;
                CFG_LONG_PRESS: r_long_press <= i_cfg.data;
                CFG_TIMEOUT:    r_timeout    <= i_cfg.data;
                CFG_LAMP:       r_lamp_pulse <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    assign front_cfg.settle_ms     = r_debounce;
    assign front_cfg.long_press_ms = r_long_press;
    assign front_cfg.lamp_pulse_ms = r_lamp_pulse;

    dc_front #(.TIMER_BITS(TIMER_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (i_tick),
        .i_cfg    (front_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_event  (push_event)
    );

    dc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_event (pop_event)
    );

    dc_back #(.TIMER_BITS(TIMER_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_event      (pop_event),
        .i_timeout_ms (r_timeout),
        .o_pop        (pop),
        .o_result     (o_result)
    );

`ifndef SYNTHESIS
    // Drives must follow the reported door state.
    a_drive_up_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.drive_up |-> o_result.door_state == DOOR_RISING)
        else $error("drive_up set outside the rising state");

    a_drive_down_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.drive_down |-> o_result.door_state == DOOR_FALLING)
        else $error("drive_down set outside the falling state");

    // The start state is left on the first tick and never reported.
    a_no_start_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.door_state != DOOR_START)
        else $error("start state reported on the result channel");

    // The queue never takes a tick while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("tick pushed into a full queue");
`endif

endmodule

// ===== tb/sv/door_controller_with_button_lock_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for door_controller_with_button_lock: drives millisecond ticks
// and timing register writes, and predicts every result with its own door model.
// Depends on dc_pkg, the channel interfaces in dc_ifs.sv and the block itself.
module door_controller_with_button_lock_tb;
    import dc_pkg::*;

    localparam int TW = TIMER_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic button;
        logic top_sw;
        logic bottom_sw;
    } tick_t;

    typedef struct packed {
        logic  drive_up;
        logic  drive_down;
        logic  lamp;
        t_door state;
    } door_out_t;

    logic i_clk;
    logic i_rst_n;

    dc_tick_if   tick_ch();
    dc_cfg_if    cfg_ch();
    dc_result_if result_ch();

    door_controller_with_button_lock dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    // Timing registers as the model sees them.
    logic [CFG_W-1:0] cfg_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0] cfg_long     = LONG_PRESS_RST;
    logic [CFG_W-1:0] cfg_timeout  = TIMEOUT_RST;
    logic [CFG_W-1:0] cfg_lamp     = LAMP_RST;

    // Door model state.
    t_door         m_state       = DOOR_START;
    logic [TW-1:0] m_state_age   = '0;
    logic [TW-1:0] m_hold_age    = '0;
    logic [TW-1:0] m_lamp_age    = '0;
    logic [TW-1:0] m_edge_age    = '0;
    logic          m_went_up     = 1'b0;
    logic          m_short_flag  = 1'b0;
    logic          m_long_flag   = 1'b0;
    logic          m_prev_btn    = 1'b1;
    logic          m_settled_btn = 1'b1;
    logic          m_held        = 1'b0;
    logic          m_long_seen   = 1'b0;
    logic          m_rearmed     = 1'b1;
    logic          m_lamp        = 1'b0;

    tick_t     ticks_todo[$];
    door_out_t outs_due[$];
    tick_t     next_tick;
    door_out_t want;

    int   ticks_queued   = 0;
    int   ticks_accepted = 0;
    int   results_seen   = 0;
    int   mismatches     = 0;
    int   settings_used  = 0;
    int   tick_gap       = 0;
    int   stall_left     = 0;
    int   quiet_cycles   = 0;
    bit   no_idle        = 1'b0;
    logic tick_done      = 1'b0;
    logic [6:0] states_seen = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic go_to(input t_door s);
        m_state = s;
        m_state_age = '0;
        m_short_flag = 1'b0;
        m_long_flag = 1'b0;
        if (s == DOOR_BOTTOM || s == DOOR_FALLING) begin
            m_went_up = 1'b0;
        end else if (s == DOOR_TOP || s == DOOR_RISING) begin
            m_went_up = 1'b1;
        end
    endtask

    task automatic predict_door_tick(input tick_t t);
        logic timed_out;
        m_state_age = sat_inc(m_state_age);
        m_hold_age = sat_inc(m_hold_age);
        m_lamp_age = sat_inc(m_lamp_age);

        if (t.button != m_prev_btn) begin
            m_prev_btn = t.button;
            m_edge_age = '0;
        end else begin
            m_edge_age = sat_inc(m_edge_age);
        end
        if (m_edge_age > cfg_debounce && t.button != m_settled_btn) begin
            m_settled_btn = t.button;
            if (!t.button) begin
                m_held = 1'b1;
                m_long_seen = 1'b0;
                m_hold_age = '0;
                m_lamp = 1'b1;
                m_lamp_age = '0;
            end else if (m_held) begin
                if (!m_long_seen) begin
                    m_short_flag = 1'b1;
                end
                m_held = 1'b0;
                m_rearmed = 1'b1;
            end
        end
        // A long press fires once per hold and needs a release before it can fire again.
        if (m_held && m_rearmed && m_hold_age >= cfg_long) begin
            m_long_flag = 1'b1;
            m_long_seen = 1'b1;
            m_rearmed = 1'b0;
        end
        if (m_lamp && m_lamp_age >= cfg_lamp) begin
            m_lamp = 1'b0;
        end

        timed_out = (m_state_age >= cfg_timeout);
        case (m_state)
            DOOR_BOTTOM: begin
                if (m_long_flag) go_to(DOOR_LOCKED);
                else if (m_short_flag) go_to(DOOR_RISING);
            end
            DOOR_LOCKED: begin
                if (m_long_flag) go_to(DOOR_BOTTOM);
            end
            DOOR_TOP: begin
                if (m_short_flag) go_to(DOOR_FALLING);
            end
            DOOR_MIDWAY: begin
                if (m_short_flag) go_to(m_went_up ? DOOR_FALLING : DOOR_RISING);
            end
            DOOR_RISING: begin
                if (m_short_flag) go_to(DOOR_MIDWAY);
                else if (!t.top_sw || timed_out) go_to(DOOR_TOP);
            end
            DOOR_FALLING: begin
                if (m_short_flag) go_to(DOOR_MIDWAY);
                else if (!t.bottom_sw || timed_out) go_to(DOOR_BOTTOM);
            end
            default: begin
                go_to(DOOR_BOTTOM);
            end
        endcase

        outs_due.push_back(door_out_t'{m_state == DOOR_RISING, m_state == DOOR_FALLING,
                                       m_lamp, m_state});
        states_seen[m_state] = 1'b1;
    endtask

    task automatic check_field(input string what, input logic [2:0] exp_v,
                               input logic [2:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t ps: %s expected %0d, got %0d", $time, what, exp_v, got_v);
            end
        end
    endtask

    // Result checking and prediction of accepted ticks.
    always @(posedge i_clk) begin
        tick_done <= i_rst_n && tick_ch.valid && tick_ch.ready;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (outs_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t ps: result request with none expected, state %0d",
                                 $time, result_ch.door_state);
                    end
                end else begin
                    want = outs_due.pop_front();
                    check_field("drive_up", 3'(want.drive_up), 3'(result_ch.drive_up));
                    check_field("drive_down", 3'(want.drive_down),
                                3'(result_ch.drive_down));
                    check_field("press_lamp", 3'(want.lamp), 3'(result_ch.press_lamp));
                    check_field("door_state", want.state, result_ch.door_state);
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                ticks_accepted++;
                predict_door_tick(tick_t'{tick_ch.button_level, tick_ch.top_switch_level,
                                          tick_ch.bottom_switch_level});
            end
        end
    end

    // Tick driver: presents queued ticks, with random gaps between requests.
    always @(negedge i_clk) begin
        if (!tick_ch.valid || tick_done) begin
            if (tick_gap != 0) begin
                tick_gap <= tick_gap - 1;
                tick_ch.valid <= 1'b0;
            end else if (ticks_todo.size() != 0) begin
                next_tick = ticks_todo.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.button_level <= next_tick.button;
                tick_ch.top_switch_level <= next_tick.top_sw;
                tick_ch.bottom_switch_level <= next_tick.bottom_sw;
                if (!no_idle && $urandom_range(0, 7) == 0) begin
                    tick_gap <= $urandom_range(1, 12);
                end
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("No request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("door_controller_with_button_lock test failed");
            $finish;
        end
    end

    task automatic queue_ticks(input logic btn, input logic top, input logic bot,
                               input int n, input bit rand_sw);
        tick_t t;
        repeat (n) begin
            t.button = btn;
            t.top_sw = rand_sw ? ($urandom_range(0, 9) != 0) : top;
            t.bottom_sw = rand_sw ? ($urandom_range(0, 9) != 0) : bot;
            ticks_todo.push_back(t);
            ticks_queued++;
        end
    endtask

    task automatic wait_idle();
        while (ticks_accepted != ticks_queued || outs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            CFG_DEBOUNCE:   cfg_debounce = val;
            CFG_LONG_PRESS: cfg_long = val;
            CFG_TIMEOUT:    cfg_timeout = val;
            CFG_LAMP:       cfg_lamp = val;
        endcase
    endtask

    task automatic apply_settings(input int deb, input int lng, input int tmo, input int lmp);
        wait_idle();
        write_reg(CFG_DEBOUNCE, deb[CFG_W-1:0]);
        write_reg(CFG_LONG_PRESS, lng[CFG_W-1:0]);
        write_reg(CFG_TIMEOUT, tmo[CFG_W-1:0]);
        write_reg(CFG_LAMP, lmp[CFG_W-1:0]);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole presses with random length, some after contact bounce, some pure noise.
    task automatic run_phase(input int deb, input int lng, input int tmo, input int lmp,
                             input int budget);
        int stop_at;
        int hold_max;
        int rel_max;
        int kind;
        apply_settings(deb, lng, tmo, lmp);
        stop_at = ticks_queued + budget;
        hold_max = deb + ((lng > 60) ? 60 : lng) + 4;
        rel_max = deb + ((tmo > 40) ? 40 : tmo) + 4;
        while (ticks_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind >= 6 && kind <= 8) begin
                repeat ($urandom_range(1, 8)) begin
                    queue_ticks(1'($urandom_range(0, 1)), 1'b1, 1'b1,
                                $urandom_range(1, deb + 1), 1'b1);
                end
            end
            if (kind <= 7) begin
                queue_ticks(1'b0, 1'b1, 1'b1, $urandom_range(1, hold_max), 1'b1);
                queue_ticks(1'b1, 1'b1, 1'b1, $urandom_range(1, rel_max), 1'b1);
            end else if (kind == 9) begin
                queue_ticks(1'b1, 1'b1, 1'b1, $urandom_range(1, rel_max), 1'b1);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.button_level = 1'b1;
        tick_ch.top_switch_level = 1'b1;
        tick_ch.bottom_switch_level = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_DEBOUNCE;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: the door leaves start for bottom on the first tick.
        queue_ticks(1'b1, 1'b1, 1'b1, 2, 1'b0);

        // Short timings, then one full cycle of the door driven by hand.
        apply_settings(1, 4, 6, 2);
        queue_ticks(1'b0, 1'b0, 1'b0, 3, 1'b0);
        queue_ticks(1'b1, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b1, 1'b0, 1'b1, 1, 1'b0);
        queue_ticks(1'b0, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b1, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b0, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b1, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b0, 1'b1, 1'b1, 3, 1'b0);
        queue_ticks(1'b1, 1'b1, 1'b1, 3, 1'b0);

        run_phase(2, 12, 20, 5, 350);
        run_phase(1, 1, 8, 1, 200);
        run_phase(0, 0, 0, 0, 150);
        run_phase(4, 30, 60, 20, 300);
        run_phase(3, 65535, 15, 65535, 150);
        run_phase(1, 6, 65535, 3, 200);

        no_idle = 1'b1;
        run_phase(2, 8, 12, 4, 150);
        wait_idle();

        $display("Ran %0d ticks under %0d timing settings and checked %0d results.",
                 ticks_accepted, settings_used, results_seen);
        $display("Door states reached (locked down to start): %b, mismatches: %0d",
                 states_seen, mismatches);
        if (mismatches == 0) begin
            $display("door_controller_with_button_lock test passed");
        end else begin
            $display("door_controller_with_button_lock test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dc_pkg.sv
hdl/dc_ifs.sv
hdl/dc_front.sv
hdl/dc_queue.sv
hdl/dc_back.sv
hdl/door_controller_with_button_lock.sv
tb/sv/door_controller_with_button_lock_tb.sv
